### design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared constants and types for the descending rank sorter.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Largest number of values in one set.
  localparam int unsigned SET_SIZE   = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = $clog2(SET_SIZE);
  localparam int unsigned CNT_W      = $clog2(SET_SIZE + 1);

  // Depth of the job queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // One classified input transaction as it travels through the queue.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              do_store;  // value is kept in the set
    logic              is_last;   // set is closed, start ranking
  } job_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RANK = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

### design/rsd_fifo.sv
// ----------------------------------------------------------------------------
// rsd_fifo
// Small synchronous job queue between the front and the back.
// ----------------------------------------------------------------------------
module rsd_fifo import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_job_o,
  output logic empty_o
);

  job_t              entry_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o    = (count_q == FCNT_W'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + FCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### design/rsd_front.sv
// ----------------------------------------------------------------------------
// rsd_front
// Accepts input transactions, keeps the set fill count and decides whether
// each value is stored, closes the set, or is dropped.
// ----------------------------------------------------------------------------
module rsd_front import rsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,
  input  logic              s_tlast_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output job_t              push_job_o
);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic             accept;
  logic             has_room;

  assign s_tready_o = !fifo_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign has_room   = (fill_q < CNT_W'(SET_SIZE));

  assign push_job_o.value    = s_tdata_i;
  assign push_job_o.do_store = has_room;
  assign push_job_o.is_last  = s_tlast_i;
  // A value past a full set is dropped unless it still has to close the set.
  assign push_o = accept && (has_room || s_tlast_i);

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (s_tlast_i) begin
        fill_d = '0;
      end else if (has_room) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

### design/rsd_back.sv
// ----------------------------------------------------------------------------
// rsd_back
// Loads a set from the queue, ranks every value against the whole set and
// streams the values out in rank order.
// ----------------------------------------------------------------------------
module rsd_back import rsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_empty_i,
  input  job_t              pop_job_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,
  output logic              m_tlast_o
);

  logic [DATA_W-1:0] val_mem  [SET_SIZE];
  logic [DATA_W-1:0] sort_mem [SET_SIZE];

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [CNT_W-1:0]  q_q, q_d;
  logic [IDX_W-1:0]  rank_q, rank_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]  emit_q, emit_d;
  logic              out_vld_q, out_vld_d;
  logic              out_last_q, out_last_d;
  logic [DATA_W-1:0] vp_q, vq_q, out_data_q;

  logic              store_wr;
  logic              rank_done;
  logic              out_load;
  logic              beats;

  assign pop_o      = (state_q == ST_LOAD) && !fifo_empty_i;
  assign store_wr   = pop_o && pop_job_i.do_store;
  assign rank_done  = (state_q == ST_RANK) && (q_q == cnt_q) && !cmp_vld_q;
  assign out_load   = (state_q == ST_EMIT) && (!out_vld_q || m_tready_i);
  // Count one more when the compared value is larger, or equal and earlier.
  assign beats      = (vq_q > vp_q) || ((vq_q == vp_q) && (cmp_idx_q < p_q));

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    q_d        = q_q;
    rank_d     = rank_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = q_q;
    emit_d     = emit_q;
    out_vld_d  = out_vld_q;
    out_last_d = out_last_q;

    if (out_vld_q && m_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (pop_o) begin
          if (pop_job_i.is_last) begin
            cnt_d   = fill_q + CNT_W'(pop_job_i.do_store);
            fill_d  = '0;
            p_d     = '0;
            q_d     = '0;
            rank_d  = '0;
            state_d = ST_RANK;
          end else if (pop_job_i.do_store) begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
      end
      ST_RANK: begin
        if (q_q != cnt_q) begin
          cmp_vld_d = 1'b1;
          q_d       = q_q + CNT_W'(1);
        end
        if (cmp_vld_q && beats) begin
          rank_d = rank_q + IDX_W'(1);
        end
        if (rank_done) begin
          rank_d = '0;
          q_d    = '0;
          p_d    = p_q + CNT_W'(1);
          if (p_q == cnt_q - CNT_W'(1)) begin
            emit_d  = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_vld_d  = 1'b1;
          out_last_d = (emit_q == cnt_q - CNT_W'(1));
          emit_d     = emit_q + CNT_W'(1);
          if (emit_q == cnt_q - CNT_W'(1)) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      fill_q     <= '0;
      cnt_q      <= '0;
      p_q        <= '0;
      q_q        <= '0;
      rank_q     <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      emit_q     <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      p_q        <= p_d;
      q_q        <= q_d;
      rank_q     <= rank_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
      emit_q     <= emit_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
    end
  end

  // Value store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      val_mem[fill_q[IDX_W-1:0]] <= pop_job_i.value;
    end
    vp_q <= val_mem[p_q[IDX_W-1:0]];
    vq_q <= val_mem[q_q[IDX_W-1:0]];
  end

  // Ranked store: written at the rank, read in order into the output register.
  always_ff @(posedge clk_i) begin
    if (rank_done) begin
      sort_mem[rank_q] <= vp_q;
    end
    if (out_load) begin
      out_data_q <= sort_mem[emit_q[IDX_W-1:0]];
    end
  end

endmodule

### design/rank_sort_descending.sv
// ----------------------------------------------------------------------------
// rank_sort_descending
// Rank sort of one set of unsigned 32-bit values, emitted in descending order.
// ----------------------------------------------------------------------------
// Values arrive one per input transaction, and the transaction with tlast high
// closes the set. Up to SET_SIZE (16) values are kept; later values of the same
// set are dropped, although a dropped value with tlast still closes the set.
// Each value is then ranked by the number of values in the set that are larger
// than it, with equal values kept in arrival order, and the set leaves in
// descending order with tlast on its final value. The front side accepts one
// transaction per cycle into a four-entry job queue while the queue has room,
// so it keeps taking the next set while the back side works. The back side
// loads one value a cycle while the queue holds jobs, then ranks the set with
// one comparator and emits one value per cycle while the output is ready.
// Ranking is bound by the single comparator and the read ports of the value
// store. No clearing pass follows reset.
module rank_sort_descending import rsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream: one value per transaction.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sample_value
  input  logic              s_axis_tlast,   // is_final
  // Output stream: sorted values, largest first.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic              m_axis_tlast    // end_of_run
);

  job_t push_job, pop_job;
  logic push, pop, fifo_full, fifo_empty;

  // The front classifies each transaction: store, close the set, or drop.
  rsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // The queue lets the front run ahead while the back ranks a set.
  rsd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (fifo_empty)
  );

  // The back stores, ranks and emits one set at a time.
  rsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .pop_job_i   (pop_job),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the descending rank sorter.
// ----------------------------------------------------------------------------
// Sets of values are streamed into the sorter. Each accepted input transaction
// is also fed to a predictor in the bench, which keeps its own copy of the set
// and ranks it when the closing value arrives. The ranked values are queued,
// and every output transaction is compared with the oldest queued value.
// Directed sets cover a single value, the extremes of the value range, equal
// values and an overflowing set. Random sets then mix sizes and value ranges.
// A final test holds the output side off for a long time so that the sorter
// fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import rsd_pkg::*;

  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned RANDOM_ITEMS = 230;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_end;
  } sorted_item_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] sample_value
  logic              s_axis_tlast  = 1'b0; // is_final
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;         // [31:0] sorted_value
  logic              m_axis_tlast;         // end_of_run

  // Predictor state: the values of the set being collected.
  logic [DATA_W-1:0] set_store [SET_SIZE];
  int unsigned       set_fill = 0;
  sorted_item_t      sorted_expect [$];

  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned random_sent   = 0;
  bit          no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;

  rank_sort_descending dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Adds one accepted value to the predicted set. When the value closes the
  // set, every stored value is ranked by the number of values above it, with
  // equal values ordered by arrival, and the set is queued in rank order.
  function automatic void absorb_sample(logic [DATA_W-1:0] value, logic final_flag);
    sorted_item_t ranked [SET_SIZE];
    int unsigned  n;
    int unsigned  r;
    // Values beyond a full set are dropped, the closing flag still counts.
    if (set_fill < SET_SIZE) begin
      set_store[set_fill] = value;
      set_fill++;
    end
    if (!final_flag) return;
    n = set_fill;
    for (int unsigned p = 0; p < n; p++) begin
      r = 0;
      for (int unsigned q = 0; q < n; q++) begin
        if (set_store[q] > set_store[p] || (set_store[q] == set_store[p] && q < p)) r++;
      end
      ranked[r].value   = set_store[p];
      ranked[r].run_end = (r + 1 == n);
    end
    for (int unsigned k = 0; k < n; k++) sorted_expect.push_back(ranked[k]);
    set_fill = 0;
  endfunction

  // Offers one value and waits until the sorter takes it. Called right after
  // a rising edge; tvalid stays high when the next value follows at once.
  task automatic send_sample(input logic [DATA_W-1:0] value, input logic final_flag);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= final_flag;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_sample(value, final_flag);
  endtask

  // The sender pauses here until every predicted result has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sorted_expect.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(int unsigned mode);
    logic [DATA_W-1:0] corners [4];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case (mode)
      0: pick_value = $urandom();
      // A narrow range makes equal values common.
      1: pick_value = $urandom_range(0, 7);
      2: pick_value = corners[$urandom_range(0, 3)];
      // Equal upper halves push the decision into the low bits.
      default: pick_value = {16'hA5C3, 16'($urandom_range(0, 15))};
    endcase
  endfunction

  task automatic send_random_set(input int unsigned count, input int unsigned mode);
    for (int unsigned k = 0; k < count; k++) begin
      send_sample(pick_value(mode), k == count - 1);
    end
  endtask

  task automatic test_single_value();
    send_sample(32'h0000_0000, 1'b1);
    wait_for_results();
  endtask

  task automatic test_extremes();
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    wait_for_results();
  endtask

  task automatic test_equal_values();
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0005, 1'b1);
    wait_for_results();
  endtask

  // A full set followed by a closing value that does not fit. If the closing
  // value were kept it would come out first, being the largest.
  task automatic test_overflow();
    for (int unsigned k = 0; k < SET_SIZE; k++) begin
      send_sample(32'h1000_0000 + k * 32'h0101_0101, 1'b0);
    end
    send_sample(32'hFFFF_FFFF, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_sets();
    int unsigned set_index;
    int unsigned count;
    int unsigned pick;
    set_index = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // A stretch of sets runs with neither side idling.
      no_idle = (set_index >= 10 && set_index < 20);
      pick = $urandom_range(0, 99);
      if (pick < 80)      count = $urandom_range(1, 8);
      else if (pick < 94) count = $urandom_range(9, SET_SIZE);
      else                count = $urandom_range(SET_SIZE + 1, SET_SIZE + 4);
      send_random_set(count, $urandom_range(0, 3));
      random_sent += count;
      set_index++;
      // Now and then the sender waits for the set to drain before going on.
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  // The output side holds off while full sets keep coming, so the job queue
  // fills and the input has to stall.
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    for (int unsigned s = 0; s < 3; s++) send_random_set(SET_SIZE, 0);
    wait_for_results();
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_taken != hold_requests) begin
      hold_taken    <= hold_taken + 1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compares every output transaction with the oldest predicted result.
  always @(posedge clk_i) begin
    sorted_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value %h end_of_run %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("sorted_value: expected %h, actual %h", want.value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("end_of_run: expected %b, actual %b", want.run_end, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_value();
    test_extremes();
    test_equal_values();
    test_overflow();
    test_random_sets();
    test_backpressure();
    // Let any stray output show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sorted_expect.size() != 0) begin
      $error("%0d results never arrived", sorted_expect.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
